@@ design/hdlc_byte_destuff_deframer_defines.svh @@
// Assertion macros used by the bound checker file.
`ifndef HDLC_BYTE_DESTUFF_DEFRAMER_DEFINES_SVH
`define HDLC_BYTE_DESTUFF_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while reset is low.
`define HBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while reset is low.
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/hdlc_bd_pkg.sv @@
package hdlc_bd_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W = 9;
	localparam int IDX_W = 2;
	localparam int MAX_FRAME = 256;

	localparam logic [BYTE_W-1:0] DEF_FLAG = 8'h7e;
	localparam logic [BYTE_W-1:0] DEF_ESCAPE = 8'h7d;
	localparam logic [BYTE_W-1:0] DEF_FLIP = 8'h20;

	// Register indexes on the configuration port
	localparam logic [IDX_W-1:0] CFG_FLAG = 2'd0;
	localparam logic [IDX_W-1:0] CFG_ESCAPE = 2'd1;
	localparam logic [IDX_W-1:0] CFG_FLIP = 2'd2;
	localparam logic [IDX_W-1:0] CFG_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_byte;
		logic [BYTE_W-1:0] escape_byte;
		logic [BYTE_W-1:0] flip_mask;
		logic [LEN_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic has_result;
		kind_t kind;
		logic [BYTE_W-1:0] data_byte;
		logic [LEN_W-1:0] frame_length;
	} result_t;

endpackage

@@ design/hdlc_bd_cfg.sv @@
module hdlc_bd_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [hdlc_bd_pkg::IDX_W-1:0] cfg_index,
	input logic [hdlc_bd_pkg::LEN_W-1:0] cfg_data,
	output hdlc_bd_pkg::cfg_t cfg
);

	logic [hdlc_bd_pkg::BYTE_W-1:0] flag_q;
	logic [hdlc_bd_pkg::BYTE_W-1:0] escape_q;
	logic [hdlc_bd_pkg::BYTE_W-1:0] flip_q;
	logic [hdlc_bd_pkg::LEN_W-1:0] limit_q;
	logic [hdlc_bd_pkg::LEN_W-1:0] limit_eff;

	// Clamp the written limit: zero acts as one, cap at the frame maximum
	always_comb begin
		priority if (cfg_data == '0) begin
			limit_eff = hdlc_bd_pkg::LEN_W'(1);
		end else if (cfg_data > hdlc_bd_pkg::LEN_W'(hdlc_bd_pkg::MAX_FRAME)) begin
			limit_eff = hdlc_bd_pkg::LEN_W'(hdlc_bd_pkg::MAX_FRAME);
		end else begin
			limit_eff = cfg_data;
		end
	end

	// Hold the registers, load on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= hdlc_bd_pkg::DEF_FLAG;
			escape_q <= hdlc_bd_pkg::DEF_ESCAPE;
			flip_q <= hdlc_bd_pkg::DEF_FLIP;
			limit_q <= hdlc_bd_pkg::LEN_W'(hdlc_bd_pkg::MAX_FRAME);
		end else if (cfg_we) begin
			unique case (cfg_index)
				hdlc_bd_pkg::CFG_FLAG: flag_q <= cfg_data[hdlc_bd_pkg::BYTE_W-1:0];
				hdlc_bd_pkg::CFG_ESCAPE: escape_q <= cfg_data[hdlc_bd_pkg::BYTE_W-1:0];
				hdlc_bd_pkg::CFG_FLIP: flip_q <= cfg_data[hdlc_bd_pkg::BYTE_W-1:0];
				hdlc_bd_pkg::CFG_LIMIT: limit_q <= limit_eff;
			endcase
		end
	end

	assign cfg.flag_byte = flag_q;
	assign cfg.escape_byte = escape_q;
	assign cfg.flip_mask = flip_q;
	assign cfg.limit = limit_q;

endmodule

@@ design/hdlc_bd_decode.sv @@
module hdlc_bd_decode (
	input logic clk,
	input logic arst_n,
	input hdlc_bd_pkg::cfg_t cfg,
	input logic [hdlc_bd_pkg::BYTE_W-1:0] rx_byte_s1,
	input logic take,
	output hdlc_bd_pkg::result_t res
);

	logic escape_q;
	logic [hdlc_bd_pkg::LEN_W-1:0] count_q;
	logic escape_d;
	logic [hdlc_bd_pkg::LEN_W-1:0] count_d;
	logic [hdlc_bd_pkg::LEN_W-1:0] count_inc;
	logic [hdlc_bd_pkg::BYTE_W-1:0] decoded;
	logic is_data;

	assign count_inc = count_q + hdlc_bd_pkg::LEN_W'(1);

	// Classify the byte: flag first, then pending escape, then escape marker
	always_comb begin
		res.has_result = 1'b1;
		res.kind = hdlc_bd_pkg::KIND_DATA;
		res.data_byte = '0;
		res.frame_length = '0;
		escape_d = escape_q;
		count_d = count_q;
		decoded = rx_byte_s1;
		is_data = 1'b0;
		priority if (rx_byte_s1 == cfg.flag_byte) begin
			res.kind = hdlc_bd_pkg::KIND_END;
			res.frame_length = count_q;
			count_d = '0;
			escape_d = 1'b0;
		end else if (escape_q) begin
			decoded = rx_byte_s1 ^ cfg.flip_mask;
			escape_d = 1'b0;
			is_data = 1'b1;
		end else if (rx_byte_s1 == cfg.escape_byte) begin
			res.has_result = 1'b0;
			escape_d = 1'b1;
		end else begin
			is_data = 1'b1;
		end
		// Count the data byte, discard the frame when the limit is reached
		if (is_data) begin
			res.data_byte = decoded;
			if (count_inc >= cfg.limit) begin
				res.kind = hdlc_bd_pkg::KIND_OVERFLOW;
				count_d = '0;
			end else begin
				count_d = count_inc;
			end
		end
	end

	// Advance the frame state once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			count_q <= '0;
		end else if (take) begin
			escape_q <= escape_d;
			count_q <= count_d;
		end
	end

endmodule

@@ design/hdlc_byte_destuff_deframer.sv @@
// Byte-destuffing frame receiver. Takes one raw line byte per beat and can
// take a new byte every cycle while the output is not stalled. The byte
// sits in an input register and is decoded into the result register once
// the result slot is free or the byte yields no result. A result thus
// passes through the input and result registers before it shows on the
// output. While a result waits on the output, one more byte is taken into
// the input register. An escape byte gives no result and moves straight on.
// Any other byte stays in the input register and holds the input side until
// the waiting result is taken. A flag byte gives a frame-end result with
// the data byte count. An escape byte flips the next byte with the mask.
// Any other byte gives a data result. That result is marked as overflow
// when the count reaches the frame limit, which then discards the frame.
// Registers: 0 flag, 1 escape, 2 flip mask, 3 frame limit (zero acts as
// one, capped at 256). Write them only while the block is idle.
module hdlc_byte_destuff_deframer (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [hdlc_bd_pkg::IDX_W-1:0] cfg_index,
	input logic [hdlc_bd_pkg::LEN_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [hdlc_bd_pkg::BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [hdlc_bd_pkg::BYTE_W-1:0] data_byte,
	output logic [hdlc_bd_pkg::LEN_W-1:0] frame_length
);

	hdlc_bd_pkg::cfg_t cfg;
	hdlc_bd_pkg::result_t res;
	logic valid_s1;
	logic [hdlc_bd_pkg::BYTE_W-1:0] rx_byte_s1;
	logic valid_s2;
	hdlc_bd_pkg::kind_t kind_s2;
	logic [hdlc_bd_pkg::BYTE_W-1:0] data_byte_s2;
	logic [hdlc_bd_pkg::LEN_W-1:0] frame_length_s2;
	logic advance;

	hdlc_bd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	hdlc_bd_decode u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.rx_byte_s1(rx_byte_s1),
		.take(advance),
		.res(res)
	);

	// Move the held byte on when the result slot is free or it yields nothing
	assign advance = valid_s1 && (!valid_s2 || out_ready || !res.has_result);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	// Result register: load a new beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.has_result) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has_result) begin
			kind_s2 <= res.kind;
			data_byte_s2 <= res.data_byte;
			frame_length_s2 <= res.frame_length;
		end
	end

	assign out_valid = valid_s2;
	assign kind = kind_s2;
	assign data_byte = data_byte_s2;
	assign frame_length = frame_length_s2;

endmodule

@@ design/hdlc_bd_checker.sv @@
`include "hdlc_byte_destuff_deframer_defines.svh"

module hdlc_bd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] kind,
	input logic [hdlc_bd_pkg::BYTE_W-1:0] data_byte,
	input logic [hdlc_bd_pkg::LEN_W-1:0] frame_length
);

	// A stalled result stays offered
	`HBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// With the result slot empty the input side never stalls
	`HBD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

	// Frame end carries a length no larger than the frame maximum and no data
	`HBD_ASSERT_NOW(a_end_fields, out_valid && kind == hdlc_bd_pkg::KIND_END, data_byte == '0 && frame_length <= hdlc_bd_pkg::LEN_W'(hdlc_bd_pkg::MAX_FRAME), "bad frame end fields")

	// Data beats carry no length, and no unused kind code appears
	`HBD_ASSERT_NOW(a_data_fields, out_valid && kind != hdlc_bd_pkg::KIND_END, frame_length == '0 && (kind == hdlc_bd_pkg::KIND_DATA || kind == hdlc_bd_pkg::KIND_OVERFLOW), "bad data beat fields")

endmodule

bind hdlc_byte_destuff_deframer hdlc_bd_checker u_hdlc_bd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.kind(kind),
	.data_byte(data_byte),
	.frame_length(frame_length)
);

@@ test/hdlc_byte_destuff_deframer_checker.sv @@
module hdlc_byte_destuff_deframer_checker
	import hdlc_bd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [IDX_W-1:0] cfg_index,
	input logic [LEN_W-1:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic [BYTE_W-1:0] rx_byte,
	input logic out_valid,
	input logic out_ready,
	input logic [1:0] kind,
	input logic [BYTE_W-1:0] data_byte,
	input logic [LEN_W-1:0] frame_length,
	output int fail_count,
	output int pending
);

	// Own copy of the registers and of the decoder state
	cfg_t cfg;
	logic esc_armed;
	logic [LEN_W-1:0] count;
	result_t due_results[$];
	result_t fresh;

	// Decode one raw line byte; has_result is low for an escape marker
	function automatic result_t destuff_byte(input logic [BYTE_W-1:0] b);
		result_t r;
		int lim;
		r = '0;
		lim = cfg.limit;
		if (lim == 0)
			lim = 1;
		if (lim > MAX_FRAME)
			lim = MAX_FRAME;
		if (b == cfg.flag_byte) begin
			// flag is tested on the raw byte, so it also cancels a pending escape
			r.has_result = 1'b1;
			r.kind = KIND_END;
			r.frame_length = count;
			count = '0;
			esc_armed = 1'b0;
		end else if (esc_armed || b != cfg.escape_byte) begin
			r.has_result = 1'b1;
			r.data_byte = esc_armed ? (b ^ cfg.flip_mask) : b;
			esc_armed = 1'b0;
			count = count + 1'b1;
			if (count >= lim) begin
				count = '0;
				r.kind = KIND_OVERFLOW;
			end else begin
				r.kind = KIND_DATA;
			end
		end else begin
			esc_armed = 1'b1;
		end
		return r;
	endfunction

	// Compare one output beat with the oldest expectation
	task automatic check_result();
		result_t want;
		if (due_results.size() == 0) begin
			$error("unexpected result: kind %0d, data_byte %0h, frame_length %0d",
				kind, data_byte, frame_length);
			fail_count++;
		end else begin
			want = due_results.pop_front();
			if (kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, kind);
				fail_count++;
			end
			if (data_byte !== want.data_byte) begin
				$error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
				fail_count++;
			end
			if (frame_length !== want.frame_length) begin
				$error("frame_length: expected %0d, got %0d", want.frame_length,
					frame_length);
				fail_count++;
			end
		end
	endtask

	// Watch both channels and the register port on every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.flag_byte = DEF_FLAG;
			cfg.escape_byte = DEF_ESCAPE;
			cfg.flip_mask = DEF_FLIP;
			cfg.limit = LEN_W'(MAX_FRAME);
			esc_armed = 1'b0;
			count = '0;
			due_results.delete();
			fail_count = 0;
		end else begin
			// results leave only after their byte has passed the input and result registers, so check before predicting
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready) begin
				fresh = destuff_byte(rx_byte);
				if (fresh.has_result)
					due_results.push_back(fresh);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FLAG: cfg.flag_byte = cfg_data[BYTE_W-1:0];
					CFG_ESCAPE: cfg.escape_byte = cfg_data[BYTE_W-1:0];
					CFG_FLIP: cfg.flip_mask = cfg_data[BYTE_W-1:0];
					CFG_LIMIT: cfg.limit = cfg_data;
				endcase
			end
		end
		pending = due_results.size();
	end

endmodule

@@ test/hdlc_byte_destuff_deframer_test.sv @@
module hdlc_byte_destuff_deframer_test;
	import hdlc_bd_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [BYTE_W-1:0] rx_byte;
	logic out_valid;
	logic out_ready;
	logic [1:0] kind;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0] frame_length;
	int fail_count;
	int pending;

	// Stimulus-side view of the current line codes, used to shape frames
	logic [BYTE_W-1:0] flag_v;
	logic [BYTE_W-1:0] esc_v;
	logic [BYTE_W-1:0] flip_v;
	bit idle_on;
	int sent;

	hdlc_byte_destuff_deframer u_top (.*);

	hdlc_byte_destuff_deframer_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("hdlc_byte_destuff_deframer_test NOT OK");
		$finish;
	end

	// Stall the output side in random bursts while idling is on
	initial begin : ready_driver
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 16);
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Offer one byte, with an optional idle burst first; hold until accepted
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
	endtask

	// Drop valid, drain the expectations, then let an in-flight escape settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FLAG: flag_v = value[BYTE_W-1:0];
			CFG_ESCAPE: esc_v = value[BYTE_W-1:0];
			CFG_FLIP: flip_v = value[BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] e,
		input logic [LEN_W-1:0] m, input logic [LEN_W-1:0] l);
		write_reg(CFG_FLAG, f);
		write_reg(CFG_ESCAPE, e);
		write_reg(CFG_FLIP, m);
		write_reg(CFG_LIMIT, l);
	endtask

	// Random byte, biased towards the flag and escape codes
	function automatic logic [BYTE_W-1:0] raw_pick();
		logic [BYTE_W-1:0] b;
		b = BYTE_W'($urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0: b = flag_v;
			1: b = esc_v;
			default: ;
		endcase
		return b;
	endfunction

	// Well-formed frame: escape the codes (and now and then a plain byte), close with flag
	task automatic send_frame(input int len);
		logic [BYTE_W-1:0] b;
		for (int i = 0; i < len; i++) begin
			b = raw_pick();
			if (b == flag_v || b == esc_v || $urandom_range(0, 15) == 0) begin
				send_byte(esc_v);
				send_byte(b ^ flip_v);
			end else begin
				send_byte(b);
			end
		end
		send_byte(flag_v);
	endtask

	// Mostly frames, some line noise, some escapes cut short by a flag
	task automatic run_traffic(input int n, input int max_len);
		int stop;
		stop = sent + n;
		while (sent < stop) begin
			case ($urandom_range(0, 9))
				0, 1: repeat ($urandom_range(1, 8)) send_byte(raw_pick());
				2: begin
					send_byte(esc_v);
					send_byte(flag_v);
				end
				default: send_frame($urandom_range(0, max_len));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FLAG;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		flag_v = DEF_FLAG;
		esc_v = DEF_ESCAPE;
		flip_v = DEF_FLIP;
		idle_on = 1'b1;
		sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of the byte, then escape corner cases on reset codes
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h55);
		send_byte(8'haa);
		send_byte(DEF_FLAG);
		// escaped byte that decodes to the flag stays data
		send_byte(DEF_ESCAPE);
		send_byte(8'h5e);
		// flag straight after an escape still closes the frame
		send_byte(DEF_ESCAPE);
		send_byte(DEF_FLAG);
		// escape after escape is unescaped data
		send_byte(DEF_ESCAPE);
		send_byte(DEF_ESCAPE);
		send_byte(DEF_FLAG);
		send_byte(DEF_FLAG);
		wait_idle();

		// Flag equal to escape, and a zero limit acting as one
		write_reg(CFG_ESCAPE, {1'b0, DEF_FLAG});
		write_reg(CFG_LIMIT, 9'd0);
		send_byte(DEF_FLAG);
		send_byte(8'h11);
		send_byte(8'h22);
		wait_idle();
		write_reg(CFG_LIMIT, 9'd1);
		send_byte(8'h33);
		send_byte(DEF_FLAG);
		wait_idle();
		write_reg(CFG_LIMIT, 9'd3);
		send_byte(8'h44);
		send_byte(8'h66);
		send_byte(8'h77);
		send_byte(DEF_FLAG);

		// Random phases over several settings; phase 3 and the last ones run without idling
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			idle_on = (ph != 3) && (ph < 6);
			case (ph)
				0: begin
					set_config(9'h000, 9'h0ff, 9'h0ff, 9'd1);
					run_traffic(30, 6);
				end
				1: begin
					// limit above the cap: overflow at the 256th byte
					set_config(9'h0ff, 9'h000, 9'h000, 9'd511);
					send_frame(270);
					run_traffic(10, 20);
				end
				2: begin
					set_config({1'b0, DEF_FLAG}, {1'b0, DEF_ESCAPE}, {1'b0, DEF_FLIP},
						LEN_W'(MAX_FRAME));
					run_traffic(30, 30);
				end
				3: begin
					set_config(LEN_W'($urandom_range(0, 255)),
						LEN_W'($urandom_range(0, 255)),
						LEN_W'($urandom_range(0, 255)), 9'd2);
					run_traffic(30, 5);
				end
				4: begin
					flag_v = BYTE_W'($urandom_range(0, 255));
					set_config({1'b0, flag_v}, {1'b0, flag_v},
						LEN_W'($urandom_range(0, 255)),
						LEN_W'($urandom_range(1, 20)));
					run_traffic(30, 10);
				end
				5: begin
					set_config(LEN_W'($urandom_range(0, 255)),
						LEN_W'($urandom_range(0, 255)),
						LEN_W'($urandom_range(0, 255)), 9'd0);
					run_traffic(30, 4);
				end
				default: begin
					// upper bit of the byte registers is dropped by the block
					set_config(LEN_W'($urandom_range(0, 511)),
						LEN_W'($urandom_range(0, 511)),
						LEN_W'($urandom_range(0, 511)),
						LEN_W'($urandom_range(0, 24)));
					run_traffic(25, 20);
				end
			endcase
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("hdlc_byte_destuff_deframer_test OK");
		else
			$display("hdlc_byte_destuff_deframer_test NOT OK");
		$finish;
	end

endmodule
